FILE: sv/bisi_pkg.sv
// shared constants, types and state codes for the bone influence slot insert block
package bisi_pkg;

    localparam int SLOTS    = 4;
    localparam int VERTICES = 4096;
    localparam int BONES    = 256;
    localparam int SHOWN    = 4;
    localparam int ONE_FX   = 65536;

    localparam int VTX_W    = 12;
    localparam int BONE_W   = 8;
    localparam int WGT_W    = 17;
    localparam int SBONE_W  = 9;
    localparam int STATUS_W = 2;
    localparam int CHG_W    = 2;

    localparam int SUM_W     = $clog2(SLOTS * ONE_FX + 1);
    localparam int QUO_W     = WGT_W;
    localparam int DIV_STEPS = QUO_W - 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VADDR_W   = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    localparam logic [SBONE_W-1:0] EMPTY_BONE = '1;
    localparam logic [WGT_W-1:0]   ONE_W      = WGT_W'(ONE_FX);
    localparam logic               OP_CLEAR   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_EMPTY    = 2'd0,
        ST_REPLACED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [SBONE_W-1:0] bone;
        logic [WGT_W-1:0]   weight;
    } slot_t;

    typedef slot_t [SLOTS-1:0] row_t;

    localparam slot_t EMPTY_SLOT = '{bone: EMPTY_BONE, weight: '0};
    localparam row_t  EMPTY_ROW  = row_t'({SLOTS{EMPTY_SLOT}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SUM,
        S_DSTART,
        S_DIV,
        S_DONE
    } state_t;

endpackage

FILE: sv/bisi_req_if.sv
// request channel: one add or clear request for a vertex
interface bisi_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [bisi_pkg::VTX_W-1:0]    vertex_index;
    logic [bisi_pkg::BONE_W-1:0]   bone_index;
    logic [bisi_pkg::WGT_W-1:0]    weight;

    modport source (output valid, op, vertex_index, bone_index, weight, input ready);
    modport sink   (input valid, op, vertex_index, bone_index, weight, output ready);
endinterface

FILE: sv/bisi_rsp_if.sv
// response channel: status and the four shown slots of the vertex
interface bisi_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bisi_pkg::STATUS_W-1:0]       status;
    logic [bisi_pkg::CHG_W-1:0]          changed_slot;
    logic signed [bisi_pkg::SBONE_W-1:0] slot0_bone;
    logic signed [bisi_pkg::SBONE_W-1:0] slot1_bone;
    logic signed [bisi_pkg::SBONE_W-1:0] slot2_bone;
    logic signed [bisi_pkg::SBONE_W-1:0] slot3_bone;
    logic [bisi_pkg::WGT_W-1:0]          slot0_weight;
    logic [bisi_pkg::WGT_W-1:0]          slot1_weight;
    logic [bisi_pkg::WGT_W-1:0]          slot2_weight;
    logic [bisi_pkg::WGT_W-1:0]          slot3_weight;

    modport source (output valid, status, changed_slot, slot0_bone, slot1_bone, slot2_bone,
                    slot3_bone, slot0_weight, slot1_weight, slot2_weight, slot3_weight,
                    input ready);
    modport sink   (input valid, status, changed_slot, slot0_bone, slot1_bone, slot2_bone,
                    slot3_bone, slot0_weight, slot1_weight, slot2_weight, slot3_weight,
                    output ready);
endinterface

FILE: sv/bisi_row_mem.sv
// vertex row memory with clearing pass after reset
module bisi_row_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [bisi_pkg::VADDR_W-1:0]  rd_addr,
    output bisi_pkg::row_t                rd_data,
    input  logic                          wr_en,
    input  logic [bisi_pkg::VADDR_W-1:0]  wr_addr,
    input  bisi_pkg::row_t                wr_data,
    output logic                          busy
);

    bisi_pkg::row_t mem [bisi_pkg::VERTICES];

    logic                         clr_busy_reg;
    logic                         clr_busy_next;
    logic [bisi_pkg::VADDR_W-1:0] clr_addr_reg;
    logic [bisi_pkg::VADDR_W-1:0] clr_addr_next;
    bisi_pkg::row_t               rd_data_reg;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == bisi_pkg::VADDR_W'(bisi_pkg::VERTICES - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= bisi_pkg::EMPTY_ROW;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

FILE: sv/bisi_div_lane.sv
// bit-serial restoring divider: weight * 1.0 / sum, one quotient bit per step
module bisi_div_lane (
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [bisi_pkg::WGT_W-1:0]  dividend,
    input  logic [bisi_pkg::SUM_W-1:0]  divisor,
    output logic [bisi_pkg::QUO_W-1:0]  quotient
);

    logic [bisi_pkg::SUM_W-1:0] rem_reg;
    logic [bisi_pkg::SUM_W-1:0] rem_next;
    logic [bisi_pkg::QUO_W-1:0] quo_reg;
    logic [bisi_pkg::QUO_W-1:0] quo_next;
    logic [bisi_pkg::SUM_W:0]   shifted;
    logic [bisi_pkg::SUM_W-1:0] ext_dividend;
    logic                       ge_start;
    logic                       ge_step;

    always_comb
    begin
        ext_dividend = bisi_pkg::SUM_W'(dividend);
        shifted      = {rem_reg, 1'b0};
        // dividend never exceeds the sum, so the top bit is set only on equality
        ge_start     = (ext_dividend >= divisor);
        ge_step      = (shifted >= {1'b0, divisor});
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            rem_next = ge_start ? (ext_dividend - divisor) : ext_dividend;
            quo_next = bisi_pkg::QUO_W'(ge_start);
        end
        else if (step)
        begin
            rem_next = ge_step ? bisi_pkg::SUM_W'(shifted - {1'b0, divisor})
                               : bisi_pkg::SUM_W'(shifted);
            quo_next = {quo_reg[bisi_pkg::QUO_W-2:0], ge_step};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

FILE: sv/bone_influence_slot_insert_core.sv
// top level: vertex slot update sequencer with bit-serial weight normalization
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   op, vertex_index, bone_index, weight
//  rsp      out  valid/ready   status, changed_slot, slot0..3 bone and weight
//
// one request at a time: with normalized weights the response follows the memory
// read, slot update, sum, divider load and 16 divider shift steps; otherwise it
// follows the read, update and sum alone. a request is taken only while idle.
// after reset a clearing pass sweeps every row of the vertex memory; req
// is not ready until it ends. a response waiting on rsp holds the next one
// back in its final state, and no new request is taken meanwhile.
module bone_influence_slot_insert_core (
    input  logic  clk,
    input  logic  rst_n,
    bisi_req_if.sink   req,
    bisi_rsp_if.source rsp
);

    bisi_pkg::state_t state_reg;
    bisi_pkg::state_t state_next;

    logic mem_busy;
    logic mem_rd_en;
    logic mem_wr_en;
    logic div_start;
    logic div_step;
    logic load_out;

    logic [bisi_pkg::STEP_W-1:0] cnt_reg;
    logic [bisi_pkg::STEP_W-1:0] cnt_next;

    // request held for the duration of the update
    logic                         op_reg;
    logic [bisi_pkg::VTX_W-1:0]   vtx_reg;
    logic [bisi_pkg::BONE_W-1:0]  bone_reg;
    logic [bisi_pkg::WGT_W-1:0]   wgt_reg;
    logic [bisi_pkg::WGT_W-1:0]   wgt_sat;

    bisi_pkg::row_t               rd_row;
    bisi_pkg::row_t               row_reg;
    bisi_pkg::status_t            status_reg;
    logic [bisi_pkg::SLOT_W-1:0]  chg_reg;
    logic                         norm_reg;
    logic                         wr_reg;
    logic                         show_reg;
    logic                         div_on_reg;
    logic [bisi_pkg::SUM_W-1:0]   sum_reg;
    logic [bisi_pkg::SUM_W-1:0]   sum_comb;

    // slot update results
    bisi_pkg::row_t               ins_row;
    bisi_pkg::status_t            ins_status;
    logic [bisi_pkg::SLOT_W-1:0]  ins_chg;
    logic                         ins_norm;
    logic                         ins_wr;
    logic                         ins_show;
    logic                         empty_found;
    logic [bisi_pkg::SLOT_W-1:0]  empty_idx;
    logic [bisi_pkg::SLOT_W-1:0]  min_idx;
    logic [bisi_pkg::WGT_W-1:0]   min_wgt;
    logic                         vtx_ok;
    logic                         bone_ok;

    logic [bisi_pkg::QUO_W-1:0]   quo [bisi_pkg::SLOTS];
    bisi_pkg::row_t               fin_row;

    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    bisi_pkg::status_t            rsp_status_reg;
    logic [bisi_pkg::CHG_W-1:0]   rsp_chg_reg;
    logic [bisi_pkg::SBONE_W-1:0] sh_bone_reg [bisi_pkg::SHOWN];
    logic [bisi_pkg::WGT_W-1:0]   sh_wgt_reg  [bisi_pkg::SHOWN];
    logic [bisi_pkg::SBONE_W-1:0] sh_bone     [bisi_pkg::SHOWN];
    logic [bisi_pkg::WGT_W-1:0]   sh_wgt      [bisi_pkg::SHOWN];

    bisi_row_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (bisi_pkg::VADDR_W'(vtx_reg)),
        .rd_data (rd_row),
        .wr_en   (mem_wr_en),
        .wr_addr (bisi_pkg::VADDR_W'(vtx_reg)),
        .wr_data (fin_row),
        .busy    (mem_busy)
    );

    for (genvar g = 0; g < bisi_pkg::SLOTS; g++)
    begin : g_lane
        bisi_div_lane u_div (
            .clk      (clk),
            .start    (div_start),
            .step     (div_step),
            .dividend (row_reg[g].weight),
            .divisor  (sum_reg),
            .quotient (quo[g])
        );
    end

    assign wgt_sat = (req.weight > bisi_pkg::ONE_W) ? bisi_pkg::ONE_W : req.weight;

    // clear empties the row; add inserts into first empty slot, else replaces first smallest if strictly larger
    always_comb
    begin
        vtx_ok      = (32'(vtx_reg) < bisi_pkg::VERTICES);
        bone_ok     = (32'(bone_reg) < bisi_pkg::BONES);
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int s = bisi_pkg::SLOTS - 1; s >= 0; s--)
        begin
            if (rd_row[s].bone == bisi_pkg::EMPTY_BONE)
            begin
                empty_found = 1'b1;
                empty_idx   = bisi_pkg::SLOT_W'(s);
            end
        end
        min_idx = '0;
        min_wgt = rd_row[0].weight;
        for (int s = 1; s < bisi_pkg::SLOTS; s++)
        begin
            if (rd_row[s].weight < min_wgt)
            begin
                min_wgt = rd_row[s].weight;
                min_idx = bisi_pkg::SLOT_W'(s);
            end
        end

        ins_row    = rd_row;
        ins_status = bisi_pkg::ST_DROPPED;
        ins_chg    = '0;
        ins_norm   = 1'b0;
        ins_wr     = 1'b0;
        ins_show   = 1'b1;
        if (!vtx_ok)
        begin
            ins_show = 1'b0;
        end
        else if (op_reg == bisi_pkg::OP_CLEAR)
        begin
            ins_row    = bisi_pkg::EMPTY_ROW;
            ins_status = bisi_pkg::ST_CLEARED;
            ins_wr     = 1'b1;
        end
        else if (bone_ok)
        begin
            ins_norm = 1'b1;
            ins_wr   = 1'b1;
            if (empty_found)
            begin
                ins_row[empty_idx].bone   = bisi_pkg::SBONE_W'(bone_reg);
                ins_row[empty_idx].weight = wgt_reg;
                ins_chg                   = empty_idx;
                ins_status                = bisi_pkg::ST_EMPTY;
            end
            else if (wgt_reg > min_wgt)
            begin
                ins_row[min_idx].bone   = bisi_pkg::SBONE_W'(bone_reg);
                ins_row[min_idx].weight = wgt_reg;
                ins_chg                 = min_idx;
                ins_status              = bisi_pkg::ST_REPLACED;
            end
        end
    end

    always_comb
    begin
        sum_comb = '0;
        for (int s = 0; s < bisi_pkg::SLOTS; s++)
        begin
            sum_comb = sum_comb + bisi_pkg::SUM_W'(row_reg[s].weight);
        end
    end

    always_comb
    begin
        for (int s = 0; s < bisi_pkg::SLOTS; s++)
        begin
            fin_row[s].bone   = row_reg[s].bone;
            fin_row[s].weight = div_on_reg ? quo[s] : row_reg[s].weight;
        end
        for (int s = 0; s < bisi_pkg::SHOWN; s++)
        begin
            sh_bone[s] = bisi_pkg::EMPTY_BONE;
            sh_wgt[s]  = '0;
            if (show_reg && (s < bisi_pkg::SLOTS))
            begin
                sh_bone[s] = fin_row[bisi_pkg::SLOT_W'(s)].bone;
                sh_wgt[s]  = fin_row[bisi_pkg::SLOT_W'(s)].weight;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        div_start  = 1'b0;
        div_step   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            bisi_pkg::S_IDLE:
            begin
                if (req.valid && !mem_busy)
                begin
                    state_next = bisi_pkg::S_READ;
                end
            end
            bisi_pkg::S_READ:
            begin
                mem_rd_en  = 1'b1;
                state_next = bisi_pkg::S_LOAD;
            end
            bisi_pkg::S_LOAD:
            begin
                state_next = bisi_pkg::S_SUM;
            end
            bisi_pkg::S_SUM:
            begin
                if (norm_reg && (sum_comb != '0))
                begin
                    state_next = bisi_pkg::S_DSTART;
                end
                else
                begin
                    state_next = bisi_pkg::S_DONE;
                end
            end
            bisi_pkg::S_DSTART:
            begin
                div_start  = 1'b1;
                cnt_next   = '0;
                state_next = bisi_pkg::S_DIV;
            end
            bisi_pkg::S_DIV:
            begin
                div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == bisi_pkg::STEP_W'(bisi_pkg::DIV_STEPS - 1))
                begin
                    state_next = bisi_pkg::S_DONE;
                end
            end
            bisi_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    mem_wr_en  = wr_reg;
                    state_next = bisi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bisi_pkg::S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bisi_pkg::S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.op;
            vtx_reg  <= req.vertex_index;
            bone_reg <= req.bone_index;
            wgt_reg  <= wgt_sat;
        end
        if (state_reg == bisi_pkg::S_LOAD)
        begin
            row_reg    <= ins_row;
            status_reg <= ins_status;
            chg_reg    <= ins_chg;
            norm_reg   <= ins_norm;
            wr_reg     <= ins_wr;
            show_reg   <= ins_show;
        end
        if (state_reg == bisi_pkg::S_SUM)
        begin
            sum_reg    <= sum_comb;
            div_on_reg <= norm_reg && (sum_comb != '0);
        end
        if (load_out)
        begin
            rsp_status_reg <= status_reg;
            rsp_chg_reg    <= bisi_pkg::CHG_W'(chg_reg);
            for (int s = 0; s < bisi_pkg::SHOWN; s++)
            begin
                sh_bone_reg[s] <= sh_bone[s];
                sh_wgt_reg[s]  <= sh_wgt[s];
            end
        end
    end

    assign req.ready        = (state_reg == bisi_pkg::S_IDLE) && !mem_busy;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.changed_slot = rsp_chg_reg;
    assign rsp.slot0_bone   = $signed(sh_bone_reg[0]);
    assign rsp.slot1_bone   = $signed(sh_bone_reg[1]);
    assign rsp.slot2_bone   = $signed(sh_bone_reg[2]);
    assign rsp.slot3_bone   = $signed(sh_bone_reg[3]);
    assign rsp.slot0_weight = sh_wgt_reg[0];
    assign rsp.slot1_weight = sh_wgt_reg[1];
    assign rsp.slot2_weight = sh_wgt_reg[2];
    assign rsp.slot3_weight = sh_wgt_reg[3];

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the bone influence slot insert core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        OP_ADD      = 1'b0;
    localparam int          POOL_SIZE   = 24;
    localparam int          N_RANDOM    = 1730;
    localparam int          DRAIN_WAIT  = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          TBL_DEPTH   = bisi_pkg::VERTICES * bisi_pkg::SLOTS;

    typedef struct packed {
        logic                        op;
        logic [bisi_pkg::VTX_W-1:0]  vertex_index;
        logic [bisi_pkg::BONE_W-1:0] bone_index;
        logic [bisi_pkg::WGT_W-1:0]  weight;
        bit                          drain_first;
    } influence_req_t;

    typedef struct packed {
        bisi_pkg::status_t                                  status;
        logic [bisi_pkg::CHG_W-1:0]                         changed;
        logic [bisi_pkg::SHOWN-1:0][bisi_pkg::SBONE_W-1:0]  bone;
        logic [bisi_pkg::SHOWN-1:0][bisi_pkg::WGT_W-1:0]    weight;
    } slot_view_t;

    logic clk;
    logic rst_n;

    bisi_req_if req_ch ();
    bisi_rsp_if rsp_ch ();

    bone_influence_slot_insert_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the vertex slot table
    logic [bisi_pkg::SBONE_W-1:0] bone_tbl [TBL_DEPTH] = '{default: bisi_pkg::EMPTY_BONE};
    logic [bisi_pkg::WGT_W-1:0]   wgt_tbl  [TBL_DEPTH] = '{default: '0};

    influence_req_t pending_reqs[$];
    slot_view_t     expected_views[$];
    influence_req_t cur_req;

    int unsigned n_total     = 0;
    int unsigned n_sent      = 0;
    int unsigned n_done_seen = 0;
    int unsigned n_recv      = 0;
    int unsigned n_errors    = 0;
    int unsigned n_cycles    = 0;
    int unsigned n_status [4] = '{default: 0};
    int unsigned vtx_pool [POOL_SIZE];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic slot_view_t apply_influence(influence_req_t r);
        slot_view_t                  v;
        int unsigned                 base;
        int unsigned                 mi;
        logic [bisi_pkg::WGT_W-1:0]  w;
        logic [bisi_pkg::WGT_W-1:0]  mw;
        longint unsigned             sum;
        bit                          placed;
        w = (r.weight > bisi_pkg::ONE_W) ? bisi_pkg::ONE_W : r.weight;
        base = r.vertex_index * bisi_pkg::SLOTS;
        v.changed = '0;
        if (r.vertex_index >= bisi_pkg::VERTICES)
        begin
            v.status = bisi_pkg::ST_DROPPED;
            for (int s = 0; s < bisi_pkg::SHOWN; s++)
            begin
                v.bone[s]   = bisi_pkg::EMPTY_BONE;
                v.weight[s] = '0;
            end
            return v;
        end
        if (r.op == bisi_pkg::OP_CLEAR)
        begin
            for (int s = 0; s < bisi_pkg::SLOTS; s++)
            begin
                bone_tbl[base+s] = bisi_pkg::EMPTY_BONE;
                wgt_tbl[base+s]  = '0;
            end
            v.status = bisi_pkg::ST_CLEARED;
        end
        else if (r.bone_index >= bisi_pkg::BONES)
        begin
            v.status = bisi_pkg::ST_DROPPED;
        end
        else
        begin
            v.status = bisi_pkg::ST_DROPPED;
            placed = 1'b0;
            for (int s = 0; s < bisi_pkg::SLOTS; s++)
            begin
                if (!placed && bone_tbl[base+s] == bisi_pkg::EMPTY_BONE)
                begin
                    bone_tbl[base+s] = bisi_pkg::SBONE_W'(r.bone_index);
                    wgt_tbl[base+s]  = w;
                    v.changed = bisi_pkg::CHG_W'(s);
                    v.status  = bisi_pkg::ST_EMPTY;
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                // first slot holding the smallest weight
                mi = 0;
                mw = wgt_tbl[base];
                for (int s = 1; s < bisi_pkg::SLOTS; s++)
                begin
                    if (wgt_tbl[base+s] < mw)
                    begin
                        mw = wgt_tbl[base+s];
                        mi = s;
                    end
                end
                if (w > mw)
                begin
                    bone_tbl[base+mi] = bisi_pkg::SBONE_W'(r.bone_index);
                    wgt_tbl[base+mi]  = w;
                    v.changed = bisi_pkg::CHG_W'(mi);
                    v.status  = bisi_pkg::ST_REPLACED;
                end
            end
            sum = 0;
            for (int s = 0; s < bisi_pkg::SLOTS; s++)
                sum += wgt_tbl[base+s];
            if (sum != 0)
            begin
                for (int s = 0; s < bisi_pkg::SLOTS; s++)
                    wgt_tbl[base+s] = bisi_pkg::WGT_W'(
                        (longint'(wgt_tbl[base+s]) * bisi_pkg::ONE_FX) / sum);
            end
        end
        for (int s = 0; s < bisi_pkg::SHOWN; s++)
        begin
            if (s < bisi_pkg::SLOTS)
            begin
                v.bone[s]   = bone_tbl[base+s];
                v.weight[s] = wgt_tbl[base+s];
            end
            else
            begin
                v.bone[s]   = bisi_pkg::EMPTY_BONE;
                v.weight[s] = '0;
            end
        end
        return v;
    endfunction

    function automatic int idle_pct(int unsigned done, bit is_sender);
        int unsigned phase;
        phase = (n_total == 0) ? 0 : done * 3 / n_total;
        case (phase)
            0:       return is_sender ? 36 : 58;
            1:       return is_sender ? 58 : 36;
            default: return 0;
        endcase
    endfunction

    task automatic push_req(logic op, int unsigned vtx, int unsigned bone, int unsigned w,
                            bit drain_first);
        influence_req_t r;
        r.op           = op;
        r.vertex_index = bisi_pkg::VTX_W'(vtx);
        r.bone_index   = bisi_pkg::BONE_W'(bone);
        r.weight       = bisi_pkg::WGT_W'(w);
        r.drain_first  = drain_first;
        pending_reqs   = {pending_reqs, r};
    endtask

    function automatic int unsigned pick_weight();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 10)
            return $urandom_range(1) ? bisi_pkg::ONE_FX : 0;
        else if (k < 25)
            return $urandom_range(255);
        else if (k < 50)
            return $urandom_range(16384);
        else if (k < 85)
            return $urandom_range(bisi_pkg::ONE_FX);
        else
            return $urandom_range(2**bisi_pkg::WGT_W - 1, bisi_pkg::ONE_FX + 1);
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch on response %0d, %s: got 0x%0h, expected 0x%0h",
                     n_recv, field, got, want);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        influence_req_t nxt;
        bit             fire;
        bit             go;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            fire = req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
                n_done_seen++;
            if (fire)
            begin
                expected_views = {expected_views, apply_influence(cur_req)};
                n_sent++;
            end
            if (!(req_ch.valid && !fire))
            begin
                go = 1'b0;
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(n_sent, 1'b1))
                begin
                    nxt = pending_reqs[0];
                    // hold-off request waits until every response is back
                    if (!nxt.drain_first || n_sent == n_done_seen)
                        go = 1'b1;
                end
                if (go)
                begin
                    void'(pending_reqs.pop_front());
                    cur_req <= nxt;
                    req_ch.op           <= nxt.op;
                    req_ch.vertex_index <= nxt.vertex_index;
                    req_ch.bone_index   <= nxt.bone_index;
                    req_ch.weight       <= nxt.weight;
                    req_ch.valid        <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        slot_view_t got;
        slot_view_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status  = bisi_pkg::status_t'(rsp_ch.status);
                got.changed = rsp_ch.changed_slot;
                got.bone    = {rsp_ch.slot3_bone, rsp_ch.slot2_bone,
                               rsp_ch.slot1_bone, rsp_ch.slot0_bone};
                got.weight  = {rsp_ch.slot3_weight, rsp_ch.slot2_weight,
                               rsp_ch.slot1_weight, rsp_ch.slot0_weight};
                if (expected_views.size() == 0)
                begin
                    report_mismatch("response with nothing outstanding", got.status, 0);
                end
                else
                begin
                    want = expected_views.pop_front();
                    n_status[want.status]++;
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (got.changed !== want.changed)
                        report_mismatch("changed_slot", got.changed, want.changed);
                    for (int s = 0; s < bisi_pkg::SHOWN; s++)
                    begin
                        if (got.bone[s] !== want.bone[s])
                            report_mismatch($sformatf("slot%0d_bone", s),
                                            got.bone[s], want.bone[s]);
                        if (got.weight[s] !== want.weight[s])
                            report_mismatch($sformatf("slot%0d_weight", s),
                                            got.weight[s], want.weight[s]);
                    end
                end
                n_recv++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct(n_recv, 1'b0));
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d responses outstanding", expected_views.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // directed: fill one vertex, saturate, drop on tie, replace smallest, clear
        push_req(OP_ADD, 0, 0, 0, 0);              // zero weight, zero sum
        push_req(OP_ADD, 0, 255, 2**bisi_pkg::WGT_W - 1, 0); // saturates to one
        push_req(OP_ADD, 0, 1, bisi_pkg::ONE_FX, 0);
        push_req(OP_ADD, 0, 2, 1, 0);
        push_req(OP_ADD, 0, 3, 0, 0);              // full, not larger than smallest
        push_req(OP_ADD, 0, 4, 100, 0);
        push_req(OP_ADD, 0, 5, 1, 0);
        push_req(bisi_pkg::OP_CLEAR, 0, 0, 0, 0);
        push_req(OP_ADD, 0, 7, 300, 0);
        push_req(bisi_pkg::OP_CLEAR, 4095, 255, 2**bisi_pkg::WGT_W - 1, 0);
        push_req(OP_ADD, 4095, 'hAA, 'h15555, 0);
        push_req(OP_ADD, 4095, 'h55, 'h0AAAA, 0);
        push_req(OP_ADD, 4095, 'hF0, bisi_pkg::ONE_FX + 1, 0);
        push_req(OP_ADD, 4095, 'h0F, 4096, 0);
        push_req(OP_ADD, 4095, 17, 0, 0);
        push_req(OP_ADD, 'hAAA, 'h80, 'h10000, 0);
        push_req(OP_ADD, 'h555, 'h7F, 'h0FFFF, 0);
        push_req(bisi_pkg::OP_CLEAR, 'h555, 0, 0, 0);
        push_req(OP_ADD, 'h555, 9, 5, 0);
        push_req(OP_ADD, 'h555, 9, 5, 0);
        push_req(OP_ADD, 'h555, 9, 5, 0);
        push_req(OP_ADD, 'h555, 9, 5, 0);
        push_req(OP_ADD, 'h555, 10, 5, 0);          // full row, replaces the smallest weight

        vtx_pool[0] = 0;
        vtx_pool[1] = bisi_pkg::VERTICES - 1;
        for (int i = 2; i < POOL_SIZE; i++)
            vtx_pool[i] = $urandom_range(bisi_pkg::VERTICES - 1);

        // random: mostly a small pool of vertices so slots fill and get replaced
        for (int i = 0; i < N_RANDOM; i++)
        begin
            push_req(($urandom_range(99) < 7) ? bisi_pkg::OP_CLEAR : OP_ADD,
                     ($urandom_range(99) < 85) ? vtx_pool[$urandom_range(POOL_SIZE - 1)]
                                               : $urandom_range(bisi_pkg::VERTICES - 1),
                     $urandom_range(255), pick_weight(),
                     (i == 0) || ($urandom_range(99) == 0));
        end
        n_total = pending_reqs.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("checked %0d of %0d requests over three idle profiles", n_recv, n_total);
        $display("outcomes: %0d into empty slot, %0d replaced, %0d dropped, %0d cleared",
                 n_status[bisi_pkg::ST_EMPTY], n_status[bisi_pkg::ST_REPLACED],
                 n_status[bisi_pkg::ST_DROPPED], n_status[bisi_pkg::ST_CLEARED]);
        if (n_errors == 0 && expected_views.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
